// File: rtl/stack_machine_executor_defines.svh
// assertion macros for the stack machine executor
`ifndef STACK_MACHINE_EXECUTOR_DEFINES_SVH
`define STACK_MACHINE_EXECUTOR_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define SME_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define SME_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/sme_pkg.sv
// shared constants and codes of the stack machine executor
package sme_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int REG_COUNT   = 8;
    localparam int CODE_DEPTH  = 256;
    localparam int WORD_WIDTH  = 32;

    localparam int SEL_W = 3;
    localparam int PTR_W = 8;

    typedef enum logic [4:0] {
        OP_LIT = 5'd1,  OP_RTN = 5'd2,  OP_LOD = 5'd3,  OP_STO = 5'd4,
        OP_CAL = 5'd5,  OP_INC = 5'd6,  OP_JMP = 5'd7,  OP_JPC = 5'd8,
        OP_WRT = 5'd9,  OP_RED = 5'd10, OP_HLT = 5'd11, OP_NEG = 5'd12,
        OP_ADD = 5'd13, OP_SUB = 5'd14, OP_MUL = 5'd15, OP_DIV = 5'd16,
        OP_ODD = 5'd17, OP_MOD = 5'd18, OP_EQL = 5'd19, OP_NEQ = 5'd20,
        OP_LSS = 5'd21, OP_LEQ = 5'd22, OP_GTR = 5'd23, OP_GEQ = 5'd24
    } t_op;

    typedef enum logic [1:0] {
        FAULT_NONE  = 2'd0,
        FAULT_DIV   = 2'd1,
        FAULT_RANGE = 2'd2
    } t_fault;

endpackage

// File: rtl/stack_machine_executor.sv
// pm/0 register stack machine executor: one instruction per input transfer
//
// channel  dir  fields (low bit first)
// s_axis   in   opcode[4:0] reg_sel[7:5] level_sel[10:8] operand[26:11]
//               read_value[58:27] (zero pad to 64)
// m_axis   out  next_pc[7:0] frame_base[15:8] stack_top[23:16] write_valid[24]
//               write_value[56:25] halted[57] fault[59:58] (zero pad to 64)
//
// one instruction at a time; the register file has one read port, so the three
// operand reads are done one after another in S_RD1, S_RD2 and S_EXEC before the
// result goes through S_OUT; the next input is taken once S_OUT has loaded the result
// lod/sto/cal add an S_WALK/S_WWAIT pass per static level walked, lod then S_LD and cal S_CAL;
// rtn adds S_RT1 and S_RT2, mul/div/mod iterate in the shared shift unit (S_MD)
// reset (synchronous, active low) clears pc, sp, halt and the valid bits that
// make never-written entries read as zero, and sets bp to 1; no memory sweep is needed
// input is taken again while a result still waits in the output register
`include "stack_machine_executor_defines.svh"

module stack_machine_executor #(
    parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH,
    parameter int CODE_DEPTH  = sme_pkg::CODE_DEPTH,
    parameter int WORD_WIDTH  = sme_pkg::WORD_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // opcode, reg_sel, level_sel, operand, read_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata   // next_pc, frame_base, stack_top, write_valid,
                                       // write_value, halted, fault
);

    localparam int W    = WORD_WIDTH;
    localparam int AW   = $clog2(STACK_DEPTH);
    localparam int RAW  = $clog2(sme_pkg::REG_COUNT);
    localparam int WX   = ((W > 8) ? W : 8) + 1;
    localparam int IW   = ((WX > 16) ? WX : 16) + 1;
    localparam int CW   = $clog2(W + 1);
    localparam int CRCP = (65536 + CODE_DEPTH - 1) / CODE_DEPTH;
    localparam int SW   = sme_pkg::SEL_W;
    localparam int PW   = sme_pkg::PTR_W;

    typedef enum logic [3:0] {
        S_IDLE, S_RD1, S_RD2, S_EXEC, S_WALK, S_WWAIT, S_LD,
        S_CAL, S_RT1, S_RT2, S_MD, S_OUT
    } t_state;

    // low 8 bits of an address reduced modulo the code depth (reciprocal multiply)
    function automatic logic [PW-1:0] code_addr(input logic [PW-1:0] v);
        logic [24:0] prod;
        logic [15:0] qd;
        prod = 25'(v) * 25'(CRCP);
        qd   = 16'(prod[23:16]) * 16'(CODE_DEPTH);
        return v - qd[PW-1:0];
    endfunction

    t_state               r_state, n_state;
    logic [4:0]           r_op, n_op;
    logic [SW-1:0]        r_rsel, n_rsel;
    logic [SW-1:0]        r_lsel, n_lsel;
    logic signed [15:0]   r_m, n_m;
    logic signed [31:0]   r_rv, n_rv;
    logic [W-1:0]         r_a, n_a, r_c, n_c, r_rr, n_rr;
    logic [PW-1:0]        r_pc, n_pc, r_bp, n_bp, r_sp, n_sp;
    logic [PW-1:0]        r_npc, n_npc, r_nbp, n_nbp, r_nsp, n_nsp;
    logic                 r_halt, n_halt;
    logic [1:0]           r_fault, n_fault;
    logic                 r_wvalid, n_wvalid;
    logic [31:0]          r_wv, n_wv;
    logic signed [WX-1:0] r_x, n_x;
    logic [2:0]           r_cnt, n_cnt;
    logic [W:0]           r_acc, n_acc;
    logic [W-1:0]         r_dvs, n_dvs, r_dvd, n_dvd;
    logic [CW-1:0]        r_mcnt, n_mcnt;
    logic                 r_na, n_na, r_nb, n_nb;
    logic [sme_pkg::REG_COUNT-1:0] r_rf_vld, n_rf_vld;
    logic [STACK_DEPTH-1:0]        r_fs_vld, n_fs_vld;
    logic                 r_rf_ok, r_fs_ok;
    logic                 r_out_valid, n_out_valid;
    logic [63:0]          r_out_data, n_out_data;

    // memory ports
    logic           rf_we;
    logic [RAW-1:0] rf_waddr, rf_raddr;
    logic [W-1:0]   rf_wdata, rf_q, rf_rd;
    logic           fs_we;
    logic [AW-1:0]  fs_waddr, fs_raddr;
    logic [W-1:0]   fs_wdata, fs_q, fs_rd;

    // helpers
    logic                 in_acc, out_load;
    logic signed [63:0]   m_ext, rv_ext;
    logic [W-1:0]         m_w, rv_w, abs_a, abs_c;
    logic signed [IW-1:0] walk_idx;
    logic                 idx_ok;
    logic [9:0]           bp_p3, sp_p4;
    logic [W:0]           md_sh, md_diff;
    logic [W-1:0]         md_quo, md_rem;
    logic                 md_qb;
    logic [PW-1:0]        o_pc, o_bp, o_sp;
    logic                 fault_commit, ptrs_kept;

    sme_ram #(.WIDTH(W), .DEPTH(sme_pkg::REG_COUNT)) u_reg_ram (
        .i_clk  (i_clk),
        .i_we   (rf_we),
        .i_waddr(rf_waddr),
        .i_wdata(rf_wdata),
        .i_raddr(rf_raddr),
        .o_rdata(rf_q)
    );

    sme_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .i_clk  (i_clk),
        .i_we   (fs_we),
        .i_waddr(fs_waddr),
        .i_wdata(fs_wdata),
        .i_raddr(fs_raddr),
        .o_rdata(fs_q)
    );

    // never-written entries read as zero
    assign rf_rd = r_rf_ok ? rf_q : '0;
    assign fs_rd = r_fs_ok ? fs_q : '0;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_load      = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign m_ext    = 64'(r_m);
    assign rv_ext   = 64'(r_rv);
    assign m_w      = m_ext[W-1:0];
    assign rv_w     = rv_ext[W-1:0];
    assign abs_a    = r_a[W-1] ? (W'(0) - r_a) : r_a;
    assign abs_c    = r_c[W-1] ? (W'(0) - r_c) : r_c;
    assign walk_idx = IW'(r_x) + IW'(r_m);
    assign idx_ok   = !walk_idx[IW-1] && (walk_idx < IW'(STACK_DEPTH));
    assign bp_p3    = 10'(r_bp) + 10'd3;
    assign sp_p4    = 10'(r_sp) + 10'd4;

    // restoring divide step
    assign md_sh   = {r_acc[W-1:0], r_dvd[W-1]};
    assign md_diff = md_sh - {1'b0, r_dvs};
    assign md_qb   = !md_diff[W];

    // result pointers: a faulted instruction leaves everything as it was
    assign o_pc = (r_fault != sme_pkg::FAULT_NONE) ? r_pc : r_npc;
    assign o_bp = (r_fault != sme_pkg::FAULT_NONE) ? r_bp : r_nbp;
    assign o_sp = (r_fault != sme_pkg::FAULT_NONE) ? r_sp : r_nsp;

    assign fault_commit = out_load && (r_fault != sme_pkg::FAULT_NONE);
    assign ptrs_kept    = (n_pc == r_pc) && (n_bp == r_bp) && (n_sp == r_sp);

    always_comb begin
        n_state = r_state;
        n_op = r_op; n_rsel = r_rsel; n_lsel = r_lsel; n_m = r_m; n_rv = r_rv;
        n_a = r_a; n_c = r_c; n_rr = r_rr;
        n_pc = r_pc; n_bp = r_bp; n_sp = r_sp; n_halt = r_halt;
        n_npc = r_npc; n_nbp = r_nbp; n_nsp = r_nsp;
        n_fault = r_fault; n_wvalid = r_wvalid; n_wv = r_wv;
        n_x = r_x; n_cnt = r_cnt;
        n_acc = r_acc; n_dvs = r_dvs; n_dvd = r_dvd; n_mcnt = r_mcnt;
        n_na = r_na; n_nb = r_nb;
        n_rf_vld = r_rf_vld; n_fs_vld = r_fs_vld;
        n_out_data = r_out_data;
        n_out_valid = (r_out_valid && !m_axis_tready);
        rf_we = 1'b0; rf_waddr = r_rsel; rf_wdata = '0; rf_raddr = r_rsel;
        fs_we = 1'b0; fs_waddr = '0; fs_wdata = '0; fs_raddr = '0;
        md_quo = '0; md_rem = '0;

        unique case (r_state)
            S_IDLE: begin
                rf_raddr = s_axis_tdata[10:8];
                if (in_acc) begin
                    n_op     = s_axis_tdata[4:0];
                    n_rsel   = s_axis_tdata[7:5];
                    n_lsel   = s_axis_tdata[10:8];
                    n_m      = s_axis_tdata[26:11];
                    n_rv     = s_axis_tdata[58:27];
                    n_nbp    = r_bp;
                    n_nsp    = r_sp;
                    n_fault  = sme_pkg::FAULT_NONE;
                    n_wvalid = 1'b0;
                    n_wv     = '0;
                    if (r_halt) begin
                        // halted: result repeats the current state
                        n_npc   = r_pc;
                        n_state = S_OUT;
                    end else begin
                        n_npc   = code_addr(r_pc + PW'(1));
                        n_state = S_RD1;
                    end
                end
            end
            S_RD1: begin
                n_a      = rf_rd;
                rf_raddr = r_m[SW-1:0];
                n_state  = S_RD2;
            end
            S_RD2: begin
                n_c      = rf_rd;
                rf_raddr = r_rsel;
                n_state  = S_EXEC;
            end
            S_EXEC: begin
                n_rr    = rf_rd;
                n_state = S_OUT;
                unique case (r_op)
                    sme_pkg::OP_LIT: begin
                        rf_we = 1'b1; rf_wdata = m_w;
                    end
                    sme_pkg::OP_RTN: begin
                        if (bp_p3 >= 10'(STACK_DEPTH)) begin
                            n_fault = sme_pkg::FAULT_RANGE;
                        end else begin
                            fs_raddr = AW'(r_bp) + AW'(2);
                            n_state  = S_RT1;
                        end
                    end
                    sme_pkg::OP_LOD, sme_pkg::OP_STO, sme_pkg::OP_CAL: begin
                        n_x     = $signed(WX'(r_bp));
                        n_cnt   = r_lsel;
                        n_state = S_WALK;
                    end
                    sme_pkg::OP_INC: n_nsp = r_sp + PW'(r_m);
                    sme_pkg::OP_JMP: n_npc = code_addr(r_m[PW-1:0]);
                    sme_pkg::OP_JPC: begin
                        if (rf_rd == '0) begin
                            n_npc = code_addr(r_m[PW-1:0]);
                        end
                    end
                    sme_pkg::OP_WRT: begin
                        n_wvalid = 1'b1; n_wv = 32'(rf_rd);
                    end
                    sme_pkg::OP_RED: begin
                        rf_we = 1'b1; rf_wdata = rv_w;
                    end
                    sme_pkg::OP_HLT: n_halt = 1'b1;
                    sme_pkg::OP_NEG: begin
                        rf_we = 1'b1; rf_wdata = W'(0) - rf_rd;
                    end
                    sme_pkg::OP_ADD: begin
                        rf_we = 1'b1; rf_wdata = r_a + r_c;
                    end
                    sme_pkg::OP_SUB: begin
                        rf_we = 1'b1; rf_wdata = r_a - r_c;
                    end
                    sme_pkg::OP_MUL: begin
                        n_acc = '0; n_dvs = r_a; n_dvd = r_c;
                        n_mcnt = CW'(W); n_state = S_MD;
                    end
                    sme_pkg::OP_DIV, sme_pkg::OP_MOD: begin
                        if (r_c == '0) begin
                            n_fault = sme_pkg::FAULT_DIV;
                        end else begin
                            n_acc = '0; n_dvs = abs_c; n_dvd = abs_a;
                            n_na = r_a[W-1]; n_nb = r_c[W-1];
                            n_mcnt = CW'(W); n_state = S_MD;
                        end
                    end
                    sme_pkg::OP_ODD: begin
                        rf_we    = 1'b1;
                        rf_wdata = !rf_rd[0] ? '0 : (rf_rd[W-1] ? '1 : W'(1));
                    end
                    sme_pkg::OP_EQL: begin
                        rf_we = 1'b1; rf_wdata = W'(r_a == r_c);
                    end
                    sme_pkg::OP_NEQ: begin
                        rf_we = 1'b1; rf_wdata = W'(r_a != r_c);
                    end
                    sme_pkg::OP_LSS: begin
                        rf_we = 1'b1; rf_wdata = W'($signed(r_a) < $signed(r_c));
                    end
                    sme_pkg::OP_LEQ: begin
                        rf_we = 1'b1; rf_wdata = W'(!($signed(r_c) < $signed(r_a)));
                    end
                    sme_pkg::OP_GTR: begin
                        rf_we = 1'b1; rf_wdata = W'($signed(r_c) < $signed(r_a));
                    end
                    sme_pkg::OP_GEQ: begin
                        rf_we = 1'b1; rf_wdata = W'(!($signed(r_a) < $signed(r_c)));
                    end
                    default: ;  // unknown opcodes only advance the counter
                endcase
            end
            S_WALK: begin
                if (r_cnt == 3'd0) begin
                    n_state = S_OUT;
                    if (r_op == sme_pkg::OP_CAL) begin
                        if (sp_p4 >= 10'(STACK_DEPTH)) begin
                            n_fault = sme_pkg::FAULT_RANGE;
                        end else begin
                            n_state = S_CAL;
                        end
                    end else if (!idx_ok) begin
                        n_fault = sme_pkg::FAULT_RANGE;
                    end else if (r_op == sme_pkg::OP_LOD) begin
                        fs_raddr = walk_idx[AW-1:0];
                        n_state  = S_LD;
                    end else begin
                        fs_we    = 1'b1;
                        fs_waddr = walk_idx[AW-1:0];
                        fs_wdata = r_rr;
                        n_fs_vld[walk_idx[AW-1:0]] = 1'b1;
                    end
                end else if (r_x < 0 || r_x >= WX'(STACK_DEPTH - 1)) begin
                    n_fault = sme_pkg::FAULT_RANGE;
                    n_state = S_OUT;
                end else begin
                    // static link sits one above the frame base
                    fs_raddr = r_x[AW-1:0] + AW'(1);
                    n_state  = S_WWAIT;
                end
            end
            S_WWAIT: begin
                n_x     = WX'($signed(fs_rd));
                n_cnt   = r_cnt - 3'd1;
                n_state = S_WALK;
            end
            S_LD: begin
                rf_we = 1'b1; rf_wdata = fs_rd;
                n_state = S_OUT;
            end
            S_CAL: begin
                // new frame: zero, static link, dynamic link, return address
                fs_we    = 1'b1;
                fs_waddr = AW'(r_sp) + AW'(r_cnt) + AW'(1);
                n_fs_vld[fs_waddr] = 1'b1;
                unique case (r_cnt[1:0])
                    2'd0: fs_wdata = '0;
                    2'd1: fs_wdata = r_x[W-1:0];
                    2'd2: fs_wdata = W'(r_bp);
                    default: fs_wdata = W'(r_npc);
                endcase
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd3) begin
                    n_nbp   = r_sp + PW'(1);
                    n_npc   = code_addr(r_m[PW-1:0]);
                    n_state = S_OUT;
                end
            end
            S_RT1: begin
                n_nbp    = fs_rd[PW-1:0];
                fs_raddr = AW'(r_bp) + AW'(3);
                n_state  = S_RT2;
            end
            S_RT2: begin
                n_npc   = code_addr(fs_rd[PW-1:0]);
                n_nsp   = r_bp - PW'(1);
                n_state = S_OUT;
            end
            S_MD: begin
                n_mcnt = r_mcnt - CW'(1);
                if (r_op == sme_pkg::OP_MUL) begin
                    n_acc = (W+1)'(r_acc[W-1:0] + (r_dvd[0] ? r_dvs : '0));
                    n_dvs = r_dvs << 1;
                    n_dvd = r_dvd >> 1;
                end else begin
                    n_acc = md_qb ? md_diff : md_sh;
                    n_dvd = {r_dvd[W-2:0], md_qb};
                end
                md_quo = (r_na ^ r_nb) ? (W'(0) - n_dvd) : n_dvd;
                md_rem = r_na ? (W'(0) - n_acc[W-1:0]) : n_acc[W-1:0];
                if (r_mcnt == CW'(1)) begin
                    rf_we   = 1'b1;
                    n_state = S_OUT;
                    priority if (r_op == sme_pkg::OP_MUL) rf_wdata = n_acc[W-1:0];
                    else if (r_op == sme_pkg::OP_DIV)     rf_wdata = md_quo;
                    else                                  rf_wdata = md_rem;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_pc        = o_pc;
                    n_bp        = o_bp;
                    n_sp        = o_sp;
                    n_out_valid = 1'b1;
                    n_out_data  = {4'd0, r_fault, r_halt, r_wv, r_wvalid, o_sp, o_bp, o_pc};
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (rf_we) begin
            n_rf_vld[rf_waddr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op; r_rsel <= n_rsel; r_lsel <= n_lsel; r_m <= n_m; r_rv <= n_rv;
        r_a <= n_a; r_c <= n_c; r_rr <= n_rr;
        r_npc <= n_npc; r_nbp <= n_nbp; r_nsp <= n_nsp;
        r_fault <= n_fault; r_wvalid <= n_wvalid; r_wv <= n_wv;
        r_x <= n_x; r_cnt <= n_cnt;
        r_acc <= n_acc; r_dvs <= n_dvs; r_dvd <= n_dvd; r_mcnt <= n_mcnt;
        r_na <= n_na; r_nb <= n_nb;
        r_out_data <= n_out_data;
        r_rf_ok <= r_rf_vld[rf_raddr];
        r_fs_ok <= r_fs_vld[fs_raddr];
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_bp        <= PW'(1);
            r_sp        <= '0;
            r_halt      <= 1'b0;
            r_rf_vld    <= '0;
            r_fs_vld    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_bp        <= n_bp;
            r_sp        <= n_sp;
            r_halt      <= n_halt;
            r_rf_vld    <= n_rf_vld;
            r_fs_vld    <= n_fs_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // halt is sticky until reset
    `SME_ASSERT_NEXT(a_halt_sticky, r_halt, r_halt, "halt flag dropped")
    // a faulted instruction commits no pointer change
    `SME_ASSERT_NOW(a_fault_keeps_state, fault_commit, ptrs_kept, "fault changed state")
    // stack memory is written only by store or call
    `SME_ASSERT_NOW(a_stack_write_src, fs_we, (r_state == S_WALK) || (r_state == S_CAL), "stray stack write")

endmodule

// File: rtl/sme_ram.sv
// generic single-write, single-read ram with registered read data
module sme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
